FILE: hw/rtl/eight_bit_cpu_exec_subset_assert.svh
// Assertion macros shared by the instruction executor RTL.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef EIGHT_BIT_CPU_EXEC_SUBSET_ASSERT_SVH
`define EIGHT_BIT_CPU_EXEC_SUBSET_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ECPU_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ECPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ecpu_pkg.sv
// Shared types and opcode constants for the eight-bit CPU instruction executor.
// No dependencies; used by every RTL module of the block.
package ecpu_pkg;

  // Register operand codes as they appear in opcode bits [5:3] and [2:0].
  typedef enum logic [2:0] {
    R_B = 3'd0,
    R_C = 3'd1,
    R_D = 3'd2,
    R_E = 3'd3,
    R_H = 3'd4,
    R_L = 3'd5,
    R_M = 3'd6,
    R_A = 3'd7
  } reg_code_t;

  // Instruction classes after decode.
  typedef enum logic [3:0] {
    K_NOP,
    K_DJNZ,
    K_JR,
    K_JRCC,
    K_LDI,
    K_INC,
    K_DEC,
    K_LDR,
    K_ADD,
    K_SUB,
    K_BAD
  } op_kind_t;

  // Exact opcodes.
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_DJNZ = 8'h10;
  localparam logic [7:0] OP_JR   = 8'h18;
  localparam logic [7:0] OP_HALT = 8'h76;

  // Opcode group masks and match values.
  localparam logic [7:0] MASK_JRCC  = 8'hE7;
  localparam logic [7:0] MATCH_JRCC = 8'h20;
  localparam logic [7:0] MASK_RY    = 8'hC7;
  localparam logic [7:0] MATCH_LDI  = 8'h06;
  localparam logic [7:0] MATCH_INC  = 8'h04;
  localparam logic [7:0] MATCH_DEC  = 8'h05;
  localparam logic [7:0] MASK_TOP2  = 8'hC0;
  localparam logic [7:0] MATCH_LDR  = 8'h40;
  localparam logic [7:0] MASK_TOP5  = 8'hF8;
  localparam logic [7:0] MATCH_ADD  = 8'h80;
  localparam logic [7:0] MATCH_SUB  = 8'h90;

  // Jump condition codes from opcode bits [4:3].
  localparam logic [1:0] CC_NZ = 2'd0;
  localparam logic [1:0] CC_Z  = 2'd1;
  localparam logic [1:0] CC_NC = 2'd2;
  localparam logic [1:0] CC_C  = 2'd3;

  // Overflow trigger values for INC and DEC.
  localparam logic [7:0] INC_OVF_VAL = 8'h7F;
  localparam logic [7:0] DEC_OVF_VAL = 8'h80;

  // Stored flags; bits 5 and 3 of the flag byte are always zero and not kept.
  typedef struct packed {
    logic s;
    logic z;
    logic h;
    logic pv;
    logic n;
    logic c;
  } flags_t;

  // Architectural state.
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [7:0]  a;
    flags_t      f;
  } arch_t;

  // Outcome of one instruction: new state plus side effects.
  typedef struct packed {
    arch_t      arch;
    logic       mem_write;
    logic [7:0] mem_wdata;
    logic       status;
  } exec_res_t;

endpackage

FILE: hw/rtl/ecpu_exec.sv
// Combinational decode and execute of one instruction against the current state.
// Depends on ecpu_pkg for state, result and opcode definitions.
module ecpu_exec (
  input  ecpu_pkg::arch_t     arch,
  input  logic [7:0]          cmd,
  input  logic [7:0]          imm_byte,
  input  logic [7:0]          hl_byte,
  output ecpu_pkg::exec_res_t res
);

  // Operand read by register code; the memory code returns the byte at HL.
  function automatic logic [7:0] read_r(ecpu_pkg::arch_t st, ecpu_pkg::reg_code_t code,
                                        logic [7:0] hlb);
    logic [7:0] v;
    unique case (code)
      ecpu_pkg::R_B: v = st.b;
      ecpu_pkg::R_C: v = st.c;
      ecpu_pkg::R_D: v = st.d;
      ecpu_pkg::R_E: v = st.e;
      ecpu_pkg::R_H: v = st.h;
      ecpu_pkg::R_L: v = st.l;
      ecpu_pkg::R_M: v = hlb;
      ecpu_pkg::R_A: v = st.a;
    endcase
    return v;
  endfunction

  ecpu_pkg::op_kind_t  kind;
  ecpu_pkg::reg_code_t y_code;
  ecpu_pkg::reg_code_t z_code;
  ecpu_pkg::arch_t     nxt;
  logic [7:0]  src_y;
  logic [7:0]  src_z;
  logic [7:0]  inc_val;
  logic [7:0]  dec_val;
  logic [7:0]  djnz_b;
  logic [8:0]  add_sum;
  logic [8:0]  sub_diff;
  logic [4:0]  add_nib;
  logic [15:0] pc_two;
  logic [15:0] target;
  logic        cc_true;
  logic        wr_en;
  logic [7:0]  wr_val;
  logic        mem_write;
  logic [7:0]  mem_wdata;
  logic        status;

  assign y_code = ecpu_pkg::reg_code_t'(cmd[5:3]);
  assign z_code = ecpu_pkg::reg_code_t'(cmd[2:0]);

  // Instruction class decode, in priority order.
  always_comb begin
    if (cmd == ecpu_pkg::OP_NOP) begin
      kind = ecpu_pkg::K_NOP;
    end else if (cmd == ecpu_pkg::OP_DJNZ) begin
      kind = ecpu_pkg::K_DJNZ;
    end else if (cmd == ecpu_pkg::OP_JR) begin
      kind = ecpu_pkg::K_JR;
    end else if ((cmd & ecpu_pkg::MASK_JRCC) == ecpu_pkg::MATCH_JRCC) begin
      kind = ecpu_pkg::K_JRCC;
    end else if ((cmd & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_LDI) begin
      kind = ecpu_pkg::K_LDI;
    end else if ((cmd & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_INC) begin
      kind = ecpu_pkg::K_INC;
    end else if ((cmd & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_DEC) begin
      kind = ecpu_pkg::K_DEC;
    end else if ((cmd & ecpu_pkg::MASK_TOP2) == ecpu_pkg::MATCH_LDR &&
                 cmd != ecpu_pkg::OP_HALT) begin
      kind = ecpu_pkg::K_LDR;
    end else if ((cmd & ecpu_pkg::MASK_TOP5) == ecpu_pkg::MATCH_ADD) begin
      kind = ecpu_pkg::K_ADD;
    end else if ((cmd & ecpu_pkg::MASK_TOP5) == ecpu_pkg::MATCH_SUB) begin
      kind = ecpu_pkg::K_SUB;
    end else begin
      kind = ecpu_pkg::K_BAD;
    end
  end

  // Operands, ALU results and branch target, all computed in parallel.
  assign src_y    = read_r(arch, y_code, hl_byte);
  assign src_z    = read_r(arch, z_code, hl_byte);
  assign inc_val  = src_y + 8'd1;
  assign dec_val  = src_y - 8'd1;
  assign djnz_b   = arch.b - 8'd1;
  assign add_sum  = {1'b0, arch.a} + {1'b0, src_z};
  assign sub_diff = {1'b0, arch.a} - {1'b0, src_z};
  assign add_nib  = {1'b0, arch.a[3:0]} + {1'b0, src_z[3:0]};
  assign pc_two   = arch.pc + 16'd2;
  assign target   = pc_two + {{8{imm_byte[7]}}, imm_byte};

  // Jump condition test.
  always_comb begin
    case (cmd[4:3])
      ecpu_pkg::CC_NZ: cc_true = !arch.f.z;
      ecpu_pkg::CC_Z:  cc_true = arch.f.z;
      ecpu_pkg::CC_NC: cc_true = !arch.f.c;
      ecpu_pkg::CC_C:  cc_true = arch.f.c;
      default:         cc_true = 1'b0;
    endcase
  end

  // Execute: next state, register write-back and memory write.
  always_comb begin
    nxt       = arch;
    nxt.pc    = arch.pc + 16'd1;
    wr_en     = 1'b0;
    wr_val    = 8'd0;
    mem_write = 1'b0;
    mem_wdata = 8'd0;
    status    = 1'b0;

    unique case (kind)
      ecpu_pkg::K_NOP: begin
      end
      ecpu_pkg::K_DJNZ: begin
        nxt.b  = djnz_b;
        nxt.pc = (djnz_b != 8'd0) ? target : pc_two;
      end
      ecpu_pkg::K_JR: begin
        nxt.pc = target;
      end
      ecpu_pkg::K_JRCC: begin
        nxt.pc = cc_true ? target : pc_two;
      end
      ecpu_pkg::K_LDI: begin
        wr_en  = 1'b1;
        wr_val = imm_byte;
        nxt.pc = pc_two;
      end
      ecpu_pkg::K_INC: begin
        wr_en    = 1'b1;
        wr_val   = inc_val;
        nxt.f.s  = inc_val[7];
        nxt.f.z  = (inc_val == 8'd0);
        nxt.f.h  = (src_y[3:0] == 4'hF);
        nxt.f.pv = (src_y == ecpu_pkg::INC_OVF_VAL);
        nxt.f.n  = 1'b0;
      end
      ecpu_pkg::K_DEC: begin
        wr_en    = 1'b1;
        wr_val   = dec_val;
        nxt.f.s  = dec_val[7];
        nxt.f.z  = (dec_val == 8'd0);
        nxt.f.h  = (src_y[3:0] == 4'h0);
        nxt.f.pv = (src_y == ecpu_pkg::DEC_OVF_VAL);
        nxt.f.n  = 1'b1;
      end
      ecpu_pkg::K_LDR: begin
        wr_en  = 1'b1;
        wr_val = src_z;
      end
      ecpu_pkg::K_ADD: begin
        nxt.a    = add_sum[7:0];
        nxt.f.s  = add_sum[7];
        nxt.f.z  = (add_sum[7:0] == 8'd0);
        nxt.f.h  = add_nib[4];
        nxt.f.pv = ~(arch.a[7] ^ src_z[7]) & (arch.a[7] ^ add_sum[7]);
        nxt.f.n  = 1'b0;
        nxt.f.c  = add_sum[8];
      end
      ecpu_pkg::K_SUB: begin
        nxt.a    = sub_diff[7:0];
        nxt.f.s  = sub_diff[7];
        nxt.f.z  = (sub_diff[7:0] == 8'd0);
        nxt.f.h  = (arch.a[3:0] < src_z[3:0]);
        nxt.f.pv = (arch.a[7] ^ src_z[7]) & (arch.a[7] ^ sub_diff[7]);
        nxt.f.n  = 1'b1;
        nxt.f.c  = sub_diff[8];
      end
      ecpu_pkg::K_BAD: begin
        status = 1'b1;
      end
      default: begin
        status = 1'b1;
      end
    endcase

    // Write-back to the destination register, or to memory at HL.
    if (wr_en) begin
      unique case (y_code)
        ecpu_pkg::R_B: nxt.b = wr_val;
        ecpu_pkg::R_C: nxt.c = wr_val;
        ecpu_pkg::R_D: nxt.d = wr_val;
        ecpu_pkg::R_E: nxt.e = wr_val;
        ecpu_pkg::R_H: nxt.h = wr_val;
        ecpu_pkg::R_L: nxt.l = wr_val;
        ecpu_pkg::R_M: begin
          mem_write = 1'b1;
          mem_wdata = wr_val;
        end
        ecpu_pkg::R_A: nxt.a = wr_val;
      endcase
    end
  end

  assign res.arch      = nxt;
  assign res.mem_write = mem_write;
  assign res.mem_wdata = mem_wdata;
  assign res.status    = status;

endmodule

FILE: hw/rtl/ecpu_state.sv
// Architectural register file: B, C, D, E, H, L, A, flags and PC.
// Depends on ecpu_pkg for the state structure.
module ecpu_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            commit,
  input  ecpu_pkg::arch_t arch_next,
  output ecpu_pkg::arch_t arch
);

  // State advances once per executed instruction; reset clears everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= '0;
    end else if (commit) begin
      arch <= arch_next;
    end
  end

endmodule

FILE: hw/rtl/eight_bit_cpu_exec_subset.sv
// Top level of the eight-bit CPU instruction executor: input register, executor, result register.
// Depends on ecpu_pkg, ecpu_exec, ecpu_state and eight_bit_cpu_exec_subset_assert.svh.
//
//   channel   direction  tdata fields (low bit up)                            tuser
//   s_axis    in         cmd, imm_byte, hl_byte                               -
//   m_axis    out        next_pc, mem_write, mem_wdata, acc_out, flags_out,   status
//                        bc_out, de_out, hl_out
//
// One instruction per cycle while the output is not stalled; each input transfer passes
// through the input register, then is executed into the result register and the register file.
// The execute step is a single pass of decode, 8-bit ALU and 16-bit branch adder.
// Reset clears the register file, flags and PC to zero and empties both registers.
// A stalled output holds its result; a new input is still taken while the input register
// is empty or is moving into the result register in the same cycle.
`include "eight_bit_cpu_exec_subset_assert.svh"

module eight_bit_cpu_exec_subset (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cmd[7:0], imm_byte[15:8], hl_byte[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[15:0], mem_write[16], mem_wdata[24:17], acc_out[32:25], flags_out[40:33],
  // bc_out[56:41], de_out[72:57], hl_out[88:73], zero fill [95:89]
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tuser   // status
);

  logic                in_valid;
  logic [7:0]          in_cmd;
  logic [7:0]          in_imm;
  logic [7:0]          in_hlb;
  logic                out_valid;
  logic [15:0]         out_npc;
  logic                out_mem_write;
  logic [7:0]          out_mem_wdata;
  logic [7:0]          out_acc;
  logic [7:0]          out_flags;
  logic [15:0]         out_bc;
  logic [15:0]         out_de;
  logic [15:0]         out_hl;
  logic                out_status;
  logic                s_fire;
  logic                m_fire;
  logic                commit;
  ecpu_pkg::arch_t     arch;
  ecpu_pkg::exec_res_t res;

  // Handshake control: execute when the result register is free or draining.
  assign commit        = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || commit;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  // Input register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (commit) begin
      in_valid <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd <= s_axis_tdata[7:0];
      in_imm <= s_axis_tdata[15:8];
      in_hlb <= s_axis_tdata[23:16];
    end
  end

  ecpu_exec u_exec (
    .arch     (arch),
    .cmd      (in_cmd),
    .imm_byte (in_imm),
    .hl_byte  (in_hlb),
    .res      (res)
  );

  ecpu_state u_state (
    .clk       (clk),
    .rst       (rst),
    .commit    (commit),
    .arch_next (res.arch),
    .arch      (arch)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload; flag byte keeps bits 5 and 3 at zero.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_npc       <= res.arch.pc;
      out_mem_write <= res.mem_write;
      out_mem_wdata <= res.mem_wdata;
      out_acc       <= res.arch.a;
      out_flags     <= {res.arch.f.s, res.arch.f.z, 1'b0, res.arch.f.h, 1'b0,
                        res.arch.f.pv, res.arch.f.n, res.arch.f.c};
      out_bc        <= {res.arch.b, res.arch.c};
      out_de        <= {res.arch.d, res.arch.e};
      out_hl        <= {res.arch.h, res.arch.l};
      out_status    <= res.status;
    end
  end

  // Output packing.
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {7'd0, out_hl, out_de, out_bc, out_flags, out_acc,
                          out_mem_wdata, out_mem_write, out_npc};

  // The input side stalls only when an instruction waits behind a blocked result.
  `ECPU_ASSERT(a_ready_stall, !s_axis_tready, in_valid && out_valid && !m_axis_tready, "input stalled without a blocked result")

  // The stored PC always matches the PC reported with the latest result.
  `ECPU_ASSERT_NEXT(a_pc_follows, commit, arch.pc == out_npc, "stored PC differs from reported next PC")

  // An unsupported opcode leaves registers and flags alone.
  `ECPU_ASSERT_NEXT(a_bad_keeps, commit && res.status, arch.a == $past(arch.a) && arch.b == $past(arch.b) && arch.h == $past(arch.h) && arch.l == $past(arch.l) && arch.f == $past(arch.f), "unsupported opcode changed state")

  // An unsupported opcode never writes memory.
  `ECPU_ASSERT(a_bad_no_write, out_valid && out_status, !out_mem_write, "memory write reported for unsupported opcode")

endmodule

FILE: tb/eight_bit_cpu_exec_subset_tb.sv
// Self-checking testbench for the eight-bit CPU instruction executor: a directed
// table, then random instruction streams with random stalls on both streams.
// Depends on ecpu_pkg and the eight_bit_cpu_exec_subset RTL.
`timescale 1ns / 100ps

module eight_bit_cpu_exec_subset_tb;

  localparam int NUM_DIR     = 25;
  localparam int NUM_RANDOM  = 400;
  localparam int PHASE_LEN   = 50;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  // One result as it leaves the block.
  typedef struct packed {
    logic [15:0] next_pc;
    logic        mem_write;
    logic [7:0]  mem_wdata;
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic        status;
  } exec_out_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct packed {
    logic [7:0] op;
    logic [7:0] imm;
    logic [7:0] mb;
    logic       typed;
    exec_out_t  want;
  } stim_row_t;

  localparam exec_out_t NO_TYPED = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Architectural state of the predicted CPU; the (HL) slot of the array is unused.
  logic [7:0]       cpu_reg [8];
  ecpu_pkg::flags_t cpu_fl;
  logic [15:0]      cpu_pc;
  logic             wr_pending;
  logic [7:0]       wr_value;

  exec_out_t   pending_results [$];
  stim_row_t   dir_rows [NUM_DIR];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          hold_req = 1'b0;

  eight_bit_cpu_exec_subset dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Classify an opcode into its instruction group.
  function automatic ecpu_pkg::op_kind_t decode_kind(logic [7:0] op);
    if (op == ecpu_pkg::OP_NOP) return ecpu_pkg::K_NOP;
    if (op == ecpu_pkg::OP_DJNZ) return ecpu_pkg::K_DJNZ;
    if (op == ecpu_pkg::OP_JR) return ecpu_pkg::K_JR;
    if ((op & ecpu_pkg::MASK_JRCC) == ecpu_pkg::MATCH_JRCC) return ecpu_pkg::K_JRCC;
    if ((op & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_LDI) return ecpu_pkg::K_LDI;
    if ((op & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_INC) return ecpu_pkg::K_INC;
    if ((op & ecpu_pkg::MASK_RY) == ecpu_pkg::MATCH_DEC) return ecpu_pkg::K_DEC;
    if ((op & ecpu_pkg::MASK_TOP2) == ecpu_pkg::MATCH_LDR && op != ecpu_pkg::OP_HALT)
      return ecpu_pkg::K_LDR;
    if ((op & ecpu_pkg::MASK_TOP5) == ecpu_pkg::MATCH_ADD) return ecpu_pkg::K_ADD;
    if ((op & ecpu_pkg::MASK_TOP5) == ecpu_pkg::MATCH_SUB) return ecpu_pkg::K_SUB;
    return ecpu_pkg::K_BAD;
  endfunction

  // Operand read: the (HL) code takes the memory byte.
  function automatic logic [7:0] fetch_operand(ecpu_pkg::reg_code_t code, logic [7:0] mb);
    return (code == ecpu_pkg::R_M) ? mb : cpu_reg[code];
  endfunction

  // Operand write: the (HL) code turns into a memory write at HL.
  function automatic void store_operand(ecpu_pkg::reg_code_t code, logic [7:0] val);
    if (code == ecpu_pkg::R_M) begin
      wr_pending = 1'b1;
      wr_value   = val;
    end else begin
      cpu_reg[code] = val;
    end
  endfunction

  // Execute one instruction on the predicted state and return the expected result.
  function automatic exec_out_t run_instr(logic [7:0] op, logic [7:0] imm, logic [7:0] mb);
    ecpu_pkg::op_kind_t  kind;
    ecpu_pkg::reg_code_t dst;
    ecpu_pkg::reg_code_t src;
    logic [7:0]  pre;
    logic [7:0]  post;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  r;
    logic [8:0]  sum;
    logic [15:0] npc;
    logic [15:0] jump_pc;
    logic        take;
    exec_out_t   o;

    kind    = decode_kind(op);
    dst     = ecpu_pkg::reg_code_t'(op[5:3]);
    src     = ecpu_pkg::reg_code_t'(op[2:0]);
    npc     = cpu_pc + 16'd1;
    jump_pc = cpu_pc + 16'd2 + {{8{imm[7]}}, imm};
    wr_pending = 1'b0;
    wr_value   = 8'h00;
    o = '0;

    case (kind)
      ecpu_pkg::K_NOP: ;
      ecpu_pkg::K_DJNZ: begin
        cpu_reg[ecpu_pkg::R_B] = cpu_reg[ecpu_pkg::R_B] - 8'd1;
        npc = (cpu_reg[ecpu_pkg::R_B] != 8'd0) ? jump_pc : cpu_pc + 16'd2;
      end
      ecpu_pkg::K_JR: npc = jump_pc;
      ecpu_pkg::K_JRCC: begin
        case (op[4:3])
          ecpu_pkg::CC_NZ: take = !cpu_fl.z;
          ecpu_pkg::CC_Z:  take = cpu_fl.z;
          ecpu_pkg::CC_NC: take = !cpu_fl.c;
          default:         take = cpu_fl.c;
        endcase
        npc = take ? jump_pc : cpu_pc + 16'd2;
      end
      ecpu_pkg::K_LDI: begin
        store_operand(dst, imm);
        npc = cpu_pc + 16'd2;
      end
      ecpu_pkg::K_INC: begin
        pre  = fetch_operand(dst, mb);
        post = pre + 8'd1;
        cpu_fl = '{s: post[7], z: post == 8'd0, h: pre[3:0] == 4'hF,
                   pv: pre == ecpu_pkg::INC_OVF_VAL, n: 1'b0, c: cpu_fl.c};
        store_operand(dst, post);
      end
      ecpu_pkg::K_DEC: begin
        pre  = fetch_operand(dst, mb);
        post = pre - 8'd1;
        cpu_fl = '{s: post[7], z: post == 8'd0, h: pre[3:0] == 4'h0,
                   pv: pre == ecpu_pkg::DEC_OVF_VAL, n: 1'b1, c: cpu_fl.c};
        store_operand(dst, post);
      end
      ecpu_pkg::K_LDR: store_operand(dst, fetch_operand(src, mb));
      ecpu_pkg::K_ADD: begin
        a   = cpu_reg[ecpu_pkg::R_A];
        v   = fetch_operand(src, mb);
        sum = {1'b0, a} + {1'b0, v};
        r   = sum[7:0];
        cpu_fl = '{s: r[7], z: r == 8'd0,
                   h: ({1'b0, a[3:0]} + {1'b0, v[3:0]}) > 5'h0F,
                   pv: (a[7] == v[7]) && (r[7] != a[7]), n: 1'b0, c: sum[8]};
        cpu_reg[ecpu_pkg::R_A] = r;
      end
      ecpu_pkg::K_SUB: begin
        a = cpu_reg[ecpu_pkg::R_A];
        v = fetch_operand(src, mb);
        r = a - v;
        cpu_fl = '{s: r[7], z: r == 8'd0, h: a[3:0] < v[3:0],
                   pv: (a[7] != v[7]) && (r[7] != a[7]), n: 1'b1, c: a < v};
        cpu_reg[ecpu_pkg::R_A] = r;
      end
      default: o.status = 1'b1;
    endcase

    cpu_pc      = npc;
    o.next_pc   = npc;
    o.mem_write = wr_pending;
    o.mem_wdata = wr_pending ? wr_value : 8'h00;
    o.acc       = cpu_reg[ecpu_pkg::R_A];
    o.flags     = {cpu_fl.s, cpu_fl.z, 1'b0, cpu_fl.h, 1'b0, cpu_fl.pv, cpu_fl.n, cpu_fl.c};
    o.bc        = {cpu_reg[ecpu_pkg::R_B], cpu_reg[ecpu_pkg::R_C]};
    o.de        = {cpu_reg[ecpu_pkg::R_D], cpu_reg[ecpu_pkg::R_E]};
    o.hl        = {cpu_reg[ecpu_pkg::R_H], cpu_reg[ecpu_pkg::R_L]};
    return o;
  endfunction

  // Bytes lean toward the boundary values that flip flags.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [8];
    corner = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  // Mostly supported instructions, with arbitrary opcodes mixed in.
  function automatic logic [7:0] pick_opcode();
    logic [2:0] y;
    logic [2:0] z;
    y = 3'($urandom);
    z = 3'($urandom);
    case ($urandom_range(0, 11))
      0, 10:   return 8'($urandom);
      1, 11:   return {2'b00, y, 3'b110};
      2:       return {2'b00, y, 3'b100};
      3:       return {2'b00, y, 3'b101};
      4, 5:    return {2'b01, y, z};
      6:       return {5'b10000, z};
      7:       return {5'b10010, z};
      8:       return {3'b001, y[1:0], 3'b000};
      default: begin
        case (y[1:0])
          2'd0:    return ecpu_pkg::OP_DJNZ;
          2'd1:    return ecpu_pkg::OP_JR;
          2'd2:    return ecpu_pkg::OP_NOP;
          default: return ecpu_pkg::OP_HALT;
        endcase
      end
    endcase
  endfunction

  // Offer one instruction, after a random gap while source idling is on, and record its expected result on transfer.
  task automatic send_item(input logic [7:0] op, input logic [7:0] imm, input logic [7:0] mb,
                           input logic typed, input exec_out_t want);
    int        gap;
    exec_out_t predicted;
    gap = src_idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 24'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {mb, imm, op};
    do @(posedge clk); while (!s_axis_tready);
    predicted = run_instr(op, imm, mb);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result(input exec_out_t got);
    exec_out_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: next_pc %h status %b", got.next_pc, got.status);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.next_pc !== want.next_pc) begin
      $error("next_pc: expected %h, got %h", want.next_pc, got.next_pc);
      mismatches++;
    end
    if (got.mem_write !== want.mem_write) begin
      $error("mem_write: expected %b, got %b", want.mem_write, got.mem_write);
      mismatches++;
    end
    if (got.mem_wdata !== want.mem_wdata) begin
      $error("mem_wdata: expected %h, got %h", want.mem_wdata, got.mem_wdata);
      mismatches++;
    end
    if (got.acc !== want.acc) begin
      $error("acc_out: expected %h, got %h", want.acc, got.acc);
      mismatches++;
    end
    if (got.flags !== want.flags) begin
      $error("flags_out: expected %h, got %h", want.flags, got.flags);
      mismatches++;
    end
    if (got.bc !== want.bc) begin
      $error("bc_out: expected %h, got %h", want.bc, got.bc);
      mismatches++;
    end
    if (got.de !== want.de) begin
      $error("de_out: expected %h, got %h", want.de, got.de);
      mismatches++;
    end
    if (got.hl !== want.hl) begin
      $error("hl_out: expected %h, got %h", want.hl, got.hl);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %b, got %b", want.status, got.status);
      mismatches++;
    end
  endtask

  // Result monitor and run limit, both on the rising edge.
  always @(posedge clk) begin
    exec_out_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("eight_bit_cpu_exec_subset_tb NOT OK");
      $finish;
    end else if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.next_pc   = m_axis_tdata[15:0];
      got.mem_write = m_axis_tdata[16];
      got.mem_wdata = m_axis_tdata[24:17];
      got.acc       = m_axis_tdata[32:25];
      got.flags     = m_axis_tdata[40:33];
      got.bc        = m_axis_tdata[56:41];
      got.de        = m_axis_tdata[72:57];
      got.hl        = m_axis_tdata[88:73];
      got.status    = m_axis_tuser;
      check_result(got);
    end
  end

  // Result receiver: a random stall before each transfer while sink idling is on, and one long hold on request.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = sink_idle_on ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk);
    end
  end

  // Reset, directed table, random streams, then drain.
  initial begin
    int mode;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    foreach (cpu_reg[i]) cpu_reg[i] = 8'h00;
    cpu_fl = '0;
    cpu_pc = 16'h0000;

    // Rows with a typed result start from the reset state and need no prediction.
    dir_rows = '{
      '{8'h00, 8'h00, 8'h00, 1'b1,
        '{16'h0001, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{ecpu_pkg::OP_HALT, 8'hFF, 8'hFF, 1'b1,
        '{16'h0002, 1'b0, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{8'h3E, 8'h7F, 8'h00, 1'b1,
        '{16'h0004, 1'b0, 8'h00, 8'h7F, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{8'h3C, 8'h00, 8'h00, 1'b1,
        '{16'h0005, 1'b0, 8'h00, 8'h80, 8'h94, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{8'h3D, 8'h00, 8'h00, 1'b0, NO_TYPED},  // DEC A from 0x80: overflow and half borrow
      '{8'h87, 8'h00, 8'h00, 1'b0, NO_TYPED},  // ADD A,A signed overflow
      '{8'h96, 8'h00, 8'hFF, 1'b0, NO_TYPED},  // SUB (HL) with borrow
      '{8'h38, 8'h10, 8'h00, 1'b0, NO_TYPED},  // JR C
      '{8'h30, 8'h10, 8'h00, 1'b0, NO_TYPED},  // JR NC
      '{8'h06, 8'h01, 8'h00, 1'b0, NO_TYPED},  // LD B,1
      '{ecpu_pkg::OP_DJNZ, 8'h05, 8'h00, 1'b0, NO_TYPED},  // B reaches zero: falls through
      '{ecpu_pkg::OP_DJNZ, 8'h80, 8'h00, 1'b0, NO_TYPED},  // B wraps to 0xFF: longest back jump
      '{ecpu_pkg::OP_JR, 8'h7F, 8'h00, 1'b0, NO_TYPED},  // longest forward jump
      '{8'h36, 8'hAB, 8'h5A, 1'b0, NO_TYPED},  // LD (HL),n
      '{8'h34, 8'h00, 8'hFF, 1'b0, NO_TYPED},  // INC (HL) wraps to zero
      '{8'h28, 8'hF0, 8'h00, 1'b0, NO_TYPED},  // JR Z
      '{8'h20, 8'hF0, 8'h00, 1'b0, NO_TYPED},  // JR NZ
      '{8'h35, 8'h00, 8'h00, 1'b0, NO_TYPED},  // DEC (HL) from zero
      '{8'h26, 8'hFF, 8'h00, 1'b0, NO_TYPED},  // LD H,0xFF
      '{8'h2E, 8'hFF, 8'h00, 1'b0, NO_TYPED},  // LD L,0xFF
      '{8'h77, 8'h00, 8'h00, 1'b0, NO_TYPED},  // LD (HL),A
      '{8'h7E, 8'h00, 8'h80, 1'b0, NO_TYPED},  // LD A,(HL)
      '{8'h86, 8'h00, 8'h80, 1'b0, NO_TYPED},  // ADD A,(HL) with carry out
      '{8'hFF, 8'h55, 8'hAA, 1'b0, NO_TYPED},  // unsupported opcode
      '{8'hCB, 8'h00, 8'h00, 1'b0, NO_TYPED}   // unsupported prefix byte
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].imm, dir_rows[i].mb, dir_rows[i].typed,
                dir_rows[i].want);

    // Random phases: the second one starves the output so the block backs up.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % PHASE_LEN == 0) begin
        mode = (i == 0) ? 0 : (i == PHASE_LEN) ? 1 : $urandom_range(0, 3);
        src_idle_on  = (mode == 0 || mode == 2);
        sink_idle_on = (mode == 0 || mode == 3);
        if (i == PHASE_LEN) hold_req = 1'b1;
      end
      send_item(pick_opcode(), pick_byte(), pick_byte(), 1'b0, NO_TYPED);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("eight_bit_cpu_exec_subset_tb OK");
    end else begin
      $display("eight_bit_cpu_exec_subset_tb NOT OK");
    end
    $finish;
  end

endmodule
